/* src/assert_macros.svh */
// Assertion macros shared by the RTL of the half-precision converter.
// Depends on nothing; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    `ASSERT_PROP(lbl, clk, rst_n, !(cond))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* src/uthf_pkg.sv */
// Types and constants of the unsigned integer to half-precision converter.
// Used by every pipeline stage and the top level; depends on nothing.
package uthf_pkg;

    // Number of low input bits examined; any set bit above them gives overflow.
    localparam int unsigned MAG_W  = 17;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned EXP_W  = 6;
    localparam int unsigned SIG_W  = 11;
    localparam int unsigned FRAC_W = 10;

    localparam logic [EXP_W-1:0] EXP_BIAS  = 6'd15;
    localparam logic [EXP_W-1:0] EXP_LIMIT = 6'd31;
    localparam logic [15:0]      OVF_CODE  = 16'hffff;
    localparam logic [POS_W-1:0] POS_TOP   = 5'd16;

    // Item after leading-one detection.
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             ovf;
        logic [POS_W-1:0] pos;
        logic [MAG_W-1:0] mag;
    } t_lead;

    // Item after normalisation, before the rounding increment.
    typedef struct packed {
        logic             valid;
        logic             zero;
        logic             ovf;
        logic             rnd;
        logic [SIG_W-1:0] sig;
        logic [EXP_W-1:0] expo;
    } t_norm;

endpackage

/* src/uint_to_half_float_convert_top.sv */
// Top level of the unsigned integer to half-precision converter.
// Depends on uthf_pkg, uthf_lead, uthf_norm, uthf_round and assert_macros.svh.

// Converts a 32-bit unsigned word to its IEEE half-precision pattern with
// round to nearest even. A new item is taken in every cycle: busy is never
// raised, so start may be held high for any run of cycles. Each item gives its
// result on o_half_bits with o_valid high for one cycle, after it passes the
// three register stages (leading-one detect, normalise, round and pack). Results
// must be taken when shown, since the output cannot be held. Zero gives 0x0000;
// any word above 131071, or any value that rounds to an exponent of 31, gives
// 0xffff.
`include "assert_macros.svh"

module uint_to_half_float_convert_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_int_value,
    output logic        o_valid,
    output logic [15:0] o_half_bits
);

    uthf_pkg::t_lead lead;
    uthf_pkg::t_norm norm;
    logic            accept;

    // The pipeline never stalls, so an item is always accepted.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    uthf_lead u_lead (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (accept),
        .i_int_value (i_int_value),
        .o_lead      (lead)
    );

    uthf_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lead  (lead),
        .o_norm  (norm)
    );

    uthf_round u_round (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_norm      (norm),
        .o_valid     (o_valid),
        .o_half_bits (o_half_bits)
    );

    // Every accepted item leaves through the lead, norm and round registers, and nothing else does.
    `ASSERT_PROP(a_item_out, i_clk, i_rst_n, accept |-> ##3 o_valid)
    `ASSERT_PROP(a_no_spurious, i_clk, i_rst_n, o_valid |-> $past(accept, 3))
    // A converted result other than the overflow code 0xffff is positive and never carries the all-ones exponent.
    `ASSERT_NEVER(a_finite_form, i_clk, i_rst_n,
        o_valid && (o_half_bits != uthf_pkg::OVF_CODE)
        && (o_half_bits[15] || (o_half_bits[14:10] == 5'h1f)))

endmodule

/* src/uthf_lead.sv */
// First stage: range check and leading-one detection of the input word.
// Depends on uthf_pkg.
module uthf_lead (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [31:0]           i_int_value,
    output uthf_pkg::t_lead       o_lead
);

    uthf_pkg::t_lead r_lead;
    uthf_pkg::t_lead n_lead;

    // Priority encoder over the low bits; the highest set bit wins.
    always_comb begin
        n_lead       = '0;
        n_lead.valid = i_valid;
        n_lead.mag   = i_int_value[uthf_pkg::MAG_W-1:0];
        n_lead.zero  = (i_int_value == 32'd0);
        n_lead.ovf   = (i_int_value[31:uthf_pkg::MAG_W] != '0);
        for (int unsigned k = 0; k < uthf_pkg::MAG_W; k++) begin
            if (i_int_value[k]) begin
                n_lead.pos = k[uthf_pkg::POS_W-1:0];
            end
        end
    end

    // Valid bit is reset; the payload is not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead.valid <= 1'b0;
        end else begin
            r_lead.valid <= n_lead.valid;
        end
        r_lead.zero <= n_lead.zero;
        r_lead.ovf  <= n_lead.ovf;
        r_lead.pos  <= n_lead.pos;
        r_lead.mag  <= n_lead.mag;
    end

    assign o_lead = r_lead;

endmodule

/* src/uthf_norm.sv */
// Second stage: shifts the leading one to the top and forms guard and sticky.
// Depends on uthf_pkg.
module uthf_norm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  uthf_pkg::t_lead       i_lead,
    output uthf_pkg::t_norm       o_norm
);

    uthf_pkg::t_norm              r_norm;
    uthf_pkg::t_norm              n_norm;
    logic [uthf_pkg::MAG_W-1:0]   norm;
    logic                         guard;
    logic                         sticky;

    // Left shift so that the leading one sits at the top bit; the eleven top
    // bits are the significand and the rest decide rounding to nearest even.
    always_comb begin
        norm   = i_lead.mag << (uthf_pkg::POS_TOP - i_lead.pos);
        guard  = norm[uthf_pkg::MAG_W-uthf_pkg::SIG_W-1];
        sticky = |norm[uthf_pkg::MAG_W-uthf_pkg::SIG_W-2:0];

        n_norm       = '0;
        n_norm.valid = i_lead.valid;
        n_norm.zero  = i_lead.zero;
        n_norm.ovf   = i_lead.ovf;
        n_norm.sig   = norm[uthf_pkg::MAG_W-1:uthf_pkg::MAG_W-uthf_pkg::SIG_W];
        n_norm.rnd   = guard && (norm[uthf_pkg::MAG_W-uthf_pkg::SIG_W] || sticky);
        n_norm.expo  = {1'b0, i_lead.pos} + uthf_pkg::EXP_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm.valid <= 1'b0;
        end else begin
            r_norm.valid <= n_norm.valid;
        end
        r_norm.zero <= n_norm.zero;
        r_norm.ovf  <= n_norm.ovf;
        r_norm.rnd  <= n_norm.rnd;
        r_norm.sig  <= n_norm.sig;
        r_norm.expo <= n_norm.expo;
    end

    assign o_norm = r_norm;

endmodule

/* src/uthf_round.sv */
// Third stage: rounding increment, renormalisation, overflow and packing.
// Depends on uthf_pkg.
module uthf_round (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  uthf_pkg::t_norm       i_norm,
    output logic                  o_valid,
    output logic [15:0]           o_half_bits
);

    logic                          r_valid;
    logic [15:0]                   r_half;
    logic [15:0]                   n_half;
    logic [uthf_pkg::SIG_W:0]      sum;
    logic                          carry;
    logic [uthf_pkg::FRAC_W-1:0]   frac;
    logic [uthf_pkg::EXP_W-1:0]    expo;

    // A carry out of the significand moves it right by one and bumps the
    // exponent; an exponent of 31 or more is overflow.
    always_comb begin
        sum   = {1'b0, i_norm.sig} + {{uthf_pkg::SIG_W{1'b0}}, i_norm.rnd};
        carry = sum[uthf_pkg::SIG_W];
        frac  = carry ? sum[uthf_pkg::FRAC_W:1] : sum[uthf_pkg::FRAC_W-1:0];
        expo  = i_norm.expo + {{(uthf_pkg::EXP_W-1){1'b0}}, carry};
        if (i_norm.zero) begin
            n_half = 16'h0000;
        end else if (i_norm.ovf || (expo >= uthf_pkg::EXP_LIMIT)) begin
            n_half = uthf_pkg::OVF_CODE;
        end else begin
            n_half = {1'b0, expo[4:0], frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_norm.valid;
        end
        r_half <= n_half;
    end

    assign o_valid     = r_valid;
    assign o_half_bits = r_half;

endmodule
